// File: sv/bse_pkg.sv
// Shared types, constants and helpers for the battery state-of-charge estimator.
package bse_pkg;

    localparam int LEVEL_W = 25;
    localparam int MV_W    = 13;

    localparam logic signed [LEVEL_W-1:0] LEVEL_FULL   = 25'sd100000;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN    = -25'sd100000;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX    = 25'sd10100000;
    localparam logic signed [LEVEL_W-1:0] CV_STEP      = 25'sd107;
    localparam logic signed [LEVEL_W-1:0] CHG_STEP     = 25'sd300;
    localparam logic signed [LEVEL_W-1:0] CHR_BOOST    = 25'sd2000;
    localparam logic signed [LEVEL_W-1:0] CHR_BOOST_LT = 25'sd1000;
    localparam logic signed [LEVEL_W-1:0] DRAIN_STEP   = 25'sd100;
    localparam logic [16:0] FULL_SCALE   = 17'd100000;
    localparam logic [16:0] CC_END_SCALE = 17'd80000;
    localparam logic [MV_W-1:0] MIN_VALID_MV = 13'd2000;

    // scaled reciprocals: ceil(2^34/1000) and ceil(2^26/5), exact for inputs below 2^24
    localparam logic [24:0] RECIP_1000 = 25'd17179870;
    localparam logic [23:0] RECIP_5    = 24'd13421773;

    localparam logic [2:0] ACT_SKIP  = 3'd0;
    localparam logic [2:0] ACT_UPD   = 3'd1;
    localparam logic [2:0] ACT_RECAL = 3'd2;
    localparam logic [2:0] ACT_CRIT  = 3'd3;
    localparam logic [2:0] ACT_LOW   = 3'd4;

    localparam logic [2:0] REG_STORED   = 3'd0;
    localparam logic [2:0] REG_FULL     = 3'd1;
    localparam logic [2:0] REG_EMPTY    = 3'd2;
    localparam logic [2:0] REG_CRIT     = 3'd3;
    localparam logic [2:0] REG_CC_START = 3'd4;
    localparam logic [2:0] REG_CC_END   = 3'd5;
    localparam logic [2:0] REG_SETTLE   = 3'd6;
    localparam logic [2:0] REG_LOW_LIM  = 3'd7;

    // numerator and quotient widths of the shared divider: 100000*8191 < 2^30
    localparam int DIV_N_W = 30;
    localparam int DIV_Q_W = 17;

    typedef struct packed {
        logic [MV_W-1:0] vbat_mv;
        logic            charging;
        logic [31:0]     now_ms;
    } sample_t;

    typedef struct packed {
        logic [6:0] percent;
        logic       percent_valid;
        logic [2:0] action;
        logic       save;
    } result_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [MV_W-1:0]    den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quo;
    } div_rsp_t;

    // level / 1000 toward zero, +1 below one, clamped 0..100
    function automatic logic [6:0] level_to_percent(input logic signed [LEVEL_W-1:0] lvl);
        logic [LEVEL_W-1:0]        mag;
        logic [2*LEVEL_W-1:0]      prod;
        logic signed [LEVEL_W-1:0] p;
        begin
            mag  = lvl[LEVEL_W-1] ? LEVEL_W'(-lvl) : LEVEL_W'(lvl);
            prod = (2*LEVEL_W)'(mag) * (2*LEVEL_W)'(RECIP_1000);
            p    = $signed(LEVEL_W'(prod[2*LEVEL_W-1:34]));
            if (lvl[LEVEL_W-1]) p = -p;
            if (p < 25'sd1) p = p + 25'sd1;
            if (p < 25'sd0) p = '0;
            if (p > 25'sd100) p = 25'sd100;
            return p[6:0];
        end
    endfunction

endpackage

// File: sv/bse_stream_if.sv
// Valid/ready stream interface carrying one payload.
interface bse_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/battery_soc_estimator.sv
// Battery state-of-charge estimator top level.
// One input transaction carries a battery sample: vbat_mv, charging, now_ms.
// Each accepted sample gives exactly one result transaction: percent,
// percent_valid, action and save.
// Configuration is written through cfg_we / cfg_index / cfg_data, by the
// user only while idle, which the block itself does not enforce; writing
// stored_percent reloads the level, validity and shown percent.
// From S_EVAL a sample goes straight to S_EMIT when skipped or shut down, via
// S_PCT for a recalibration at a curve end, via S_APPLY and S_PCT for an
// update with a boundary target, and via S_WAIT, S_APPLY and S_PCT when the
// shared bit-serial divider (17 steps) maps the voltage through a curve.
// One sample is processed at a time: in.ready is low from accept until its
// result has been moved to the output register.
// The output register holds its result while out.ready is low; a finished
// result then waits in the block and in.ready stays low until it moves on.
// Reset: level invalid (stored_percent -1), last charge state unknown, low
// count zero, last saved percent 253, not halted; registers to their
// documented defaults.
module battery_soc_estimator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    bse_stream_if.sink   in,
    bse_stream_if.source out
);
    import bse_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_APPLY = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_PCT   = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [MV_W-1:0]   full_reg, empty_reg, crit_reg, ccs_reg, cce_reg;
    logic [15:0]       settle_reg;
    logic [3:0]        lim_reg;

    logic signed [LEVEL_W-1:0] level_reg, level_next;
    logic              valid_reg, valid_next;
    logic [6:0]        shown_reg, shown_next;
    logic [1:0]        lastch_reg, lastch_next;
    logic [31:0]       ctime_reg, ctime_next;
    logic [3:0]        lowc_reg, lowc_next;
    logic [7:0]        saved_reg, saved_next;
    logic              halted_reg, halted_next;

    sample_t smp_reg;
    logic    recal_reg, recal_next;     // current sample recalibrates the level
    result_t res_reg, res_next;
    logic    res_pend_reg, res_pend_next;
    result_t out_reg;
    logic    out_valid_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    bse_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg   <= 13'd4100;
            empty_reg  <= 13'd3500;
            crit_reg   <= 13'd3400;
            ccs_reg    <= 13'd3650;
            cce_reg    <= 13'd4100;
            settle_reg <= 16'd10000;
            lim_reg    <= 4'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STORED:   ;   // applied straight to the level state
                REG_FULL:     full_reg   <= cfg_data[MV_W-1:0];
                REG_EMPTY:    empty_reg  <= cfg_data[MV_W-1:0];
                REG_CRIT:     crit_reg   <= cfg_data[MV_W-1:0];
                REG_CC_START: ccs_reg    <= cfg_data[MV_W-1:0];
                REG_CC_END:   cce_reg    <= cfg_data[MV_W-1:0];
                REG_SETTLE:   settle_reg <= cfg_data;
                REG_LOW_LIM:  lim_reg    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    logic signed [LEVEL_W-1:0] cfg_level;
    assign cfg_level = LEVEL_W'(cfg_data[6:0]) * 25'sd1000;

    logic [MV_W-1:0]           v;
    logic                      ch;
    logic [31:0]               tdiff, ctime_eff;
    logic [3:0]                lowc_eff;
    logic signed [LEVEL_W-1:0] lvl, tgt, gap, dq;
    logic [2*LEVEL_W-2:0]      gprod;
    logic [6:0]                pct;
    logic signed [7:0]         cfg_sp;

    assign v      = smp_reg.vbat_mv;
    assign ch     = smp_reg.charging;
    assign cfg_sp = cfg_data[7:0];

    always_comb
    begin
        state_next    = state_reg;
        level_next    = level_reg;
        valid_next    = valid_reg;
        shown_next    = shown_reg;
        lastch_next   = lastch_reg;
        ctime_next    = ctime_reg;
        lowc_next     = lowc_reg;
        saved_next    = saved_reg;
        halted_next   = halted_reg;
        recal_next    = recal_reg;
        res_next      = res_reg;
        res_pend_next = res_pend_reg;
        dreq          = '0;
        ctime_eff     = ctime_reg;
        tdiff         = '0;
        lowc_eff      = lowc_reg;
        lvl           = level_reg;
        tgt           = '0;
        gap           = '0;
        dq            = '0;
        gprod         = '0;
        pct           = '0;

        if (cfg_we && cfg_index == REG_STORED)
        begin
            if (cfg_sp >= 8'sd0 && cfg_sp <= 8'sd100)
            begin
                valid_next = 1'b1;
                level_next = cfg_level;
                // a stored zero still shows one percent
                shown_next = (cfg_sp == 8'sd0) ? 7'd1 : cfg_sp[6:0];
            end
            else
            begin
                valid_next = 1'b0;
                level_next = '0;
                shown_next = '0;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in.valid && !res_pend_reg)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                res_next.percent_valid = valid_reg;
                res_next.action        = ACT_SKIP;
                res_next.save          = 1'b0;
                res_next.percent       = shown_reg;
                state_next             = S_EMIT;
                if (halted_reg || v < MIN_VALID_MV)
                begin
                end
                else if (!ch && v < crit_reg)
                begin
                    shown_next = '0;
                    valid_next = 1'b1;
                    halted_next = 1'b1;
                    res_next = '{percent: 7'd0, percent_valid: 1'b1,
                                 action: ACT_CRIT, save: 1'b1};
                end
                else
                begin
                    if (lastch_reg != {1'b0, ch} || ctime_reg == 32'd0)
                    begin
                        ctime_eff   = smp_reg.now_ms;
                        lastch_next = {1'b0, ch};
                    end
                    ctime_next = ctime_eff;
                    tdiff      = smp_reg.now_ms - ctime_eff;
                    if (tdiff < {16'd0, settle_reg})
                    begin
                    end
                    else if (!valid_reg)
                    begin
                        if (!ch)
                        begin
                            recal_next = 1'b1;
                            if (v >= full_reg || v <= empty_reg)
                            begin
                                level_next = (v >= full_reg) ? LEVEL_FULL : '0;
                                valid_next = 1'b1;
                                state_next = S_PCT;
                            end
                            else
                            begin
                                dreq.start = 1'b1;
                                dreq.num   = DIV_N_W'(FULL_SCALE * 30'(v - empty_reg));
                                dreq.den   = full_reg - empty_reg;
                                state_next = S_WAIT;
                            end
                        end
                    end
                    else
                    begin
                        recal_next = 1'b0;
                        if (!ch && v < empty_reg && lowc_reg < 4'd15)
                            lowc_eff = lowc_reg + 4'd1;
                        if (ch)
                            lowc_eff = '0;
                        lowc_next = lowc_eff;
                        if (lowc_eff > lim_reg)
                        begin
                            shown_next  = '0;
                            halted_next = 1'b1;
                            res_next = '{percent: 7'd0, percent_valid: valid_reg,
                                         action: ACT_LOW, save: 1'b1};
                        end
                        else if (ch && v >= ccs_reg && v < cce_reg)
                        begin
                            dreq.start = 1'b1;
                            dreq.num   = DIV_N_W'(CC_END_SCALE * 30'(v - ccs_reg));
                            dreq.den   = cce_reg - ccs_reg;
                            state_next = S_WAIT;
                        end
                        else if (!ch && v > empty_reg && v < full_reg)
                        begin
                            dreq.start = 1'b1;
                            dreq.num   = DIV_N_W'(FULL_SCALE * 30'(v - empty_reg));
                            dreq.den   = full_reg - empty_reg;
                            state_next = S_WAIT;
                        end
                        else
                        begin
                            // boundary targets need no divide
                            state_next = S_APPLY;
                        end
                    end
                end
            end
            S_WAIT:
            begin
                if (drsp.done)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next = S_PCT;
                if (recal_reg)
                begin
                    level_next = LEVEL_W'(drsp.quo);
                    valid_next = 1'b1;
                end
                else
                begin
                    if (ch)
                    begin
                        if (v < ccs_reg)
                            tgt = '0;
                        else if (v >= cce_reg)
                        begin
                            tgt = level_reg + CV_STEP;
                            if (tgt > LEVEL_FULL) tgt = LEVEL_FULL;
                            lvl = tgt;
                        end
                        else
                            tgt = LEVEL_W'(drsp.quo);
                        if (tgt > lvl)
                        begin
                            if (lvl < CHR_BOOST_LT) lvl = lvl + CHR_BOOST;
                            lvl = lvl + CHG_STEP;
                        end
                    end
                    else
                    begin
                        if (v >= full_reg)       tgt = LEVEL_FULL;
                        else if (v <= empty_reg) tgt = '0;
                        else                     tgt = LEVEL_W'(drsp.quo);
                        if (tgt < lvl)
                        begin
                            gap   = lvl - tgt;
                            // gap / 5 by reciprocal multiply
                            gprod = (2*LEVEL_W-1)'(gap) * (2*LEVEL_W-1)'(RECIP_5);
                            dq    = (gap < DRAIN_STEP) ? DRAIN_STEP :
                                    LEVEL_W'(gprod[2*LEVEL_W-2:26]);
                            lvl   = lvl - dq;
                        end
                    end
                    if (lvl < LEVEL_MIN) lvl = LEVEL_MIN;
                    if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
                    level_next = lvl;
                end
            end
            S_PCT:
            begin
                state_next = S_EMIT;
                pct        = level_to_percent(level_reg);
                shown_next = pct;
                if (recal_reg)
                    res_next = '{percent: pct, percent_valid: 1'b1,
                                 action: ACT_RECAL, save: 1'b1};
                else
                begin
                    res_next   = '{percent: pct, percent_valid: valid_reg,
                                   action: ACT_UPD, save: (saved_reg != {1'b0, pct})};
                    saved_next = {1'b0, pct};
                end
            end
            S_EMIT:
            begin
                res_pend_next = 1'b1;
                state_next    = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        if (res_pend_reg && (!out_valid_reg || out.ready))
            res_pend_next = 1'b0;
    end

    logic in_take;
    assign in_take  = in.valid && in.ready;
    assign in.ready = (state_reg == S_IDLE) && !res_pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= '0;
            valid_reg     <= 1'b0;
            shown_reg     <= '0;
            lastch_reg    <= 2'd3;
            ctime_reg     <= '0;
            lowc_reg      <= '0;
            saved_reg     <= 8'd253;
            halted_reg    <= 1'b0;
            recal_reg     <= 1'b0;
            res_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            level_reg    <= level_next;
            valid_reg    <= valid_next;
            shown_reg    <= shown_next;
            lastch_reg   <= lastch_next;
            ctime_reg    <= ctime_next;
            lowc_reg     <= lowc_next;
            saved_reg    <= saved_next;
            halted_reg   <= halted_next;
            recal_reg    <= recal_next;
            res_pend_reg <= res_pend_next;
            if (res_pend_reg && (!out_valid_reg || out.ready))
                out_valid_reg <= 1'b1;
            else if (out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            smp_reg <= in.data;
        res_reg <= res_next;
        if (res_pend_reg && (!out_valid_reg || out.ready))
            out_reg <= res_reg;
    end

    assign out.valid = out_valid_reg;
    assign out.data  = out_reg;

`ifndef ASSERT_OFF
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in.ready)
        else $error("input ready while sample in flight");
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared");
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (state_reg == S_WAIT))
        else $error("divider finished outside wait");
    a_shutdown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && (out.data.action == ACT_CRIT || out.data.action == ACT_LOW))
        |-> (out.data.percent == 7'd0 && out.data.save))
        else $error("shutdown result not zero with save");
`endif
endmodule

// File: sv/bse_divider.sv
// Restoring bit-serial divider, one quotient bit per cycle.
module bse_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  bse_pkg::div_req_t req,
    output bse_pkg::div_rsp_t rsp
);
    import bse_pkg::*;

    logic [DIV_N_W-1:0] num_reg, num_next;
    logic [MV_W:0]      rem_reg, rem_next;
    logic [MV_W-1:0]    den_reg, den_next;
    logic [DIV_Q_W-1:0] quo_reg, quo_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [MV_W+1:0]    trial;

    // quotient fits 17 bits, so the top 13 numerator bits divided by den are zero
    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (req.start)
        begin
            num_next  = req.num << (DIV_N_W - DIV_Q_W);
            rem_next  = {1'b0, req.num[DIV_N_W-1:DIV_Q_W]};
            den_next  = req.den;
            cnt_next  = 5'(DIV_Q_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, num_reg[DIV_N_W-1]} - {2'b00, den_reg};
            if (!trial[MV_W+1])
            begin
                rem_next = trial[MV_W:0];
                quo_next = {quo_reg[DIV_Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[MV_W-1:0], num_reg[DIV_N_W-1]};
                quo_next = {quo_reg[DIV_Q_W-2:0], 1'b0};
            end
            num_next = num_reg << 1;
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule
